FILE: rtl/mrms_pkg.sv
// ----------------------------------------------------------------------------
// Memory region map sanitizer package
// Shared types and constants for the sorting chain and the merge unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mrms_pkg;

  localparam int ADDR_W      = 52;
  localparam int SIZE_W      = 52;
  localparam int END_W       = 53;
  localparam int GAP_W       = 24;
  localparam int CFG_DATA_W  = 52;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_MERGE_GAP = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_SIZE  = 1'd1;

  localparam logic [GAP_W-1:0]  GAP_RESET = 24'h00_1000;
  localparam logic [SIZE_W-1:0] MIN_RESET = 52'h0_0000_0010_0000;

  typedef struct packed {
    logic [ADDR_W-1:0] region_base;
    logic [SIZE_W-1:0] region_size;
    logic              last_region;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] span_base;
    logic [SIZE_W-1:0] span_size;
    logic              span_last;
    logic              none_left;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
  } region_t;

  typedef struct packed {
    logic    valid;
    region_t region;
  } wave_t;

  typedef struct packed {
    logic    valid;
    logic    first;
    logic    final_pop;
    region_t region;
  } pop_t;

endpackage

`default_nettype wire

FILE: rtl/mrms_cell.sv
// ----------------------------------------------------------------------------
// Sorting cell
// Holds one region of the ascending chain. Insertion waves travel to the
// right one cell per cycle; during unload the chain shifts to the left.
// ----------------------------------------------------------------------------
`default_nettype none

module mrms_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 5
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   shift,
  input  mrms_pkg::wave_t       wave_in,
  input  wire  [IDX_W-1:0]      wave_in_idx,
  input  mrms_pkg::region_t     right_held,
  output mrms_pkg::wave_t       wave_out,
  output logic [IDX_W-1:0]      wave_out_idx,
  output mrms_pkg::region_t     held
);

  logic              settle;
  logic              take;
  logic              out_valid;
  mrms_pkg::region_t out_region;

  // The wave of the n-th item of a list finds cell n empty.
  assign settle = (wave_in_idx == IDX_W'(INDEX));
  assign take   = settle || (wave_in.region.base < held.base);

  assign wave_out = '{valid: out_valid, region: out_region};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (shift) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= wave_in.valid && !settle;
    end
  end

  always_ff @(posedge clk) begin
    wave_out_idx <= wave_in_idx;
    if (shift) begin
      held <= right_held;
    end else if (wave_in.valid) begin
      if (take) begin
        held       <= wave_in.region;
        out_region <= held;
      end else begin
        out_region <= wave_in.region;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mrms_merge.sv
// ----------------------------------------------------------------------------
// Span merge unit
// Merges the sorted region stream into spans, filters them by size and
// presents the survivors with the final one marked, or flags none_left.
// ----------------------------------------------------------------------------
`default_nettype none

module mrms_merge (
  input  wire                               clk,
  input  wire                               rst,
  input  mrms_pkg::pop_t                    pop,
  input  wire  [mrms_pkg::GAP_W-1:0]        merge_gap,
  input  wire  [mrms_pkg::SIZE_W-1:0]       min_region_size,
  output logic                              result_valid,
  output mrms_pkg::out_item_t               result
);

  localparam int END_W = mrms_pkg::END_W;

  logic                        p_valid;
  logic                        p_first;
  logic                        p_final;
  logic [mrms_pkg::ADDR_W-1:0] p_base;
  logic [END_W-1:0]            p_end;

  logic [mrms_pkg::ADDR_W-1:0] cur_base;
  logic [END_W-1:0]            cur_end;
  logic                        flush;
  logic                        join_span;

  logic                        close_valid;
  logic                        close_tail;
  logic [mrms_pkg::ADDR_W-1:0] close_base;
  logic [END_W-1:0]            close_end;

  logic                        b_valid;
  logic                        b_tail;
  logic [mrms_pkg::ADDR_W-1:0] b_base;
  logic [mrms_pkg::SIZE_W-1:0] b_size;
  logic [END_W-1:0]            diff;

  logic                        keep;
  logic                        have_pend;
  logic                        fin;
  logic [mrms_pkg::ADDR_W-1:0] pend_base;
  logic [mrms_pkg::SIZE_W-1:0] pend_size;

  assign join_span = ({2'b00, p_base} <= ({1'b0, cur_end} + (END_W + 1)'(merge_gap)));
  assign diff      = close_end - END_W'(close_base);
  assign keep      = (b_size >= min_region_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid      <= 1'b0;
      flush        <= 1'b0;
      close_valid  <= 1'b0;
      close_tail   <= 1'b0;
      b_valid      <= 1'b0;
      b_tail       <= 1'b0;
      have_pend    <= 1'b0;
      fin          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      p_valid     <= pop.valid;
      flush       <= p_valid && p_final;
      close_valid <= (p_valid && !p_first && !join_span) || flush;
      close_tail  <= flush;
      b_valid     <= close_valid;
      b_tail      <= close_valid && close_tail;
      fin         <= b_valid && b_tail;
      if (fin) begin
        have_pend    <= 1'b0;
        result_valid <= 1'b1;
      end else if (b_valid && keep) begin
        have_pend    <= 1'b1;
        result_valid <= have_pend;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_first <= pop.first;
    p_final <= pop.final_pop;
    p_base  <= pop.region.base;
    p_end   <= END_W'(pop.region.base) + END_W'(pop.region.size);

    if (p_valid) begin
      if (p_first || !join_span) begin
        cur_base   <= p_base;
        cur_end    <= p_end;
        close_base <= cur_base;
        close_end  <= cur_end;
      end else if (p_end > cur_end) begin
        cur_end <= p_end;
      end
    end else if (flush) begin
      close_base <= cur_base;
      close_end  <= cur_end;
    end

    b_base <= close_base;
    if (diff[END_W-1]) begin
      b_size <= '1;
    end else begin
      b_size <= diff[mrms_pkg::SIZE_W-1:0];
    end

    if (fin) begin
      if (have_pend) begin
        result.span_base <= pend_base;
        result.span_size <= pend_size;
        result.span_last <= 1'b1;
        result.none_left <= 1'b0;
      end else begin
        result.span_base <= '0;
        result.span_size <= '0;
        result.span_last <= 1'b0;
        result.none_left <= 1'b1;
      end
    end else if (b_valid && keep) begin
      result.span_base <= pend_base;
      result.span_size <= pend_size;
      result.span_last <= 1'b0;
      result.none_left <= 1'b0;
      pend_base        <= b_base;
      pend_size        <= b_size;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/memory_region_map_sanitizer.sv
// ----------------------------------------------------------------------------
// Memory region map sanitizer
// Sorts a list of memory regions, merges neighbors and drops small spans.
// ----------------------------------------------------------------------------
// An input transfer happens at a clock edge with start high and busy low.
// While busy is low, regions load at one per cycle into a chain of
// MAX_REGIONS sorting cells, which insert each region in ascending base
// order as it travels down the chain. Regions beyond MAX_REGIONS are
// dropped. The transfer that carries last_region ends the list and
// raises busy. Processing then lets the last insertion settle, shifts
// the stored regions out of the chain through the merge unit, and passes
// them through the merge and filter pipeline.
// Each span appears for one cycle with result_valid high; span_last marks
// the final one, or a single result with none_left high reports that no
// span survived. Busy falls after that final result, so one list is
// handled at a time. Results cannot be held off by the receiver.
// Reset clears the list and loads the default gap and minimum size.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_region_map_sanitizer #(
  parameter int MAX_REGIONS = 32
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  output logic                                busy,
  input  mrms_pkg::in_item_t                  region,
  input  wire                                 cfg_write,
  input  wire  [mrms_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [mrms_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                result_valid,
  output mrms_pkg::out_item_t                 result
);

  localparam int IDX_W = $clog2(MAX_REGIONS);
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  typedef enum logic [1:0] {
    S_LOAD,
    S_DRAIN,
    S_UNLOAD,
    S_FINISH
  } state_t;

  state_t                      state;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            timer;
  logic [CNT_W-1:0]            pop_idx;
  logic                        accept;
  logic                        room;
  logic                        shift;

  logic [mrms_pkg::GAP_W-1:0]  merge_gap;
  logic [mrms_pkg::SIZE_W-1:0] min_region_size;

  mrms_pkg::wave_t             wave     [MAX_REGIONS+1];
  logic [IDX_W-1:0]            wave_idx [MAX_REGIONS+1];
  mrms_pkg::region_t           held     [MAX_REGIONS];
  logic [MAX_REGIONS-1:0]      wave_busy;
  mrms_pkg::pop_t              pop;

  assign busy   = (state != S_LOAD);
  assign accept = start && !busy;
  assign room   = (count < CNT_W'(MAX_REGIONS));
  assign shift  = (state == S_UNLOAD);

  assign wave[0]     = '{valid: accept && room,
                         region: '{base: region.region_base, size: region.region_size}};
  assign wave_idx[0] = count[IDX_W-1:0];

  genvar k;
  generate
    for (k = 0; k < MAX_REGIONS; k++) begin : g_cell
      mrms_cell #(
        .INDEX (k),
        .IDX_W (IDX_W)
      ) u_cell (
        .clk          (clk),
        .rst          (rst),
        .shift        (shift),
        .wave_in      (wave[k]),
        .wave_in_idx  (wave_idx[k]),
        .right_held   (held[(k == MAX_REGIONS - 1) ? k : k + 1]),
        .wave_out     (wave[k+1]),
        .wave_out_idx (wave_idx[k+1]),
        .held         (held[k])
      );
      assign wave_busy[k] = wave[k+1].valid;
    end
  endgenerate

  assign pop.valid     = (state == S_UNLOAD);
  assign pop.first     = (pop_idx == '0);
  assign pop.final_pop = (pop_idx == count - CNT_W'(1));
  assign pop.region    = held[0];

  mrms_merge u_merge (
    .clk             (clk),
    .rst             (rst),
    .pop             (pop),
    .merge_gap       (merge_gap),
    .min_region_size (min_region_size),
    .result_valid    (result_valid),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      merge_gap       <= mrms_pkg::GAP_RESET;
      min_region_size <= mrms_pkg::MIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        mrms_pkg::REG_MERGE_GAP: merge_gap       <= cfg_data[mrms_pkg::GAP_W-1:0];
        mrms_pkg::REG_MIN_SIZE:  min_region_size <= cfg_data[mrms_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      count   <= '0;
      timer   <= '0;
      pop_idx <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (room) begin
              count <= count + CNT_W'(1);
            end
            if (region.last_region) begin
              timer <= '0;
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          timer <= timer + CNT_W'(1);
          if (timer == CNT_W'(MAX_REGIONS - 1)) begin
            pop_idx <= '0;
            state   <= S_UNLOAD;
          end
        end
        S_UNLOAD: begin
          pop_idx <= pop_idx + CNT_W'(1);
          if (pop.final_pop) begin
            count <= '0;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (result_valid && (result.span_last || result.none_left)) begin
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((state == S_UNLOAD) || (state == S_FINISH)))
    else $error("result transfer outside of the unload and finish phases");

  a_chain_settled: assert property (@(posedge clk) disable iff (rst)
    (state == S_UNLOAD) |-> (wave_busy == '0))
    else $error("insertion wave still moving during unload");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_REGIONS))
    else $error("region count beyond chain length");

  a_unload_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_UNLOAD) |-> (count != '0) && (pop_idx < count))
    else $error("unload with no stored region");

  a_empty_result_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.none_left) |->
      (result.span_base == '0) && (result.span_size == '0) && !result.span_last)
    else $error("empty result carries span data");

endmodule

`default_nettype wire

FILE: verif/mrms_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Memory region map sanitizer checker
// Watches the region, configuration and result ports of the sanitizer. It
// keeps its own copy of the region list and limits, sorts and merges each
// finished list, and compares every result transfer with the oldest span due.
// ----------------------------------------------------------------------------

module mrms_checker #(
  parameter int MAX_REGIONS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  mrms_pkg::in_item_t                  region,
  input  logic                                cfg_write,
  input  logic [mrms_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mrms_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                result_valid,
  input  mrms_pkg::out_item_t                 result,
  output int                                  fail_count,
  output int                                  pending
);

  localparam logic [63:0] SIZE_CAP = {12'd0, {mrms_pkg::SIZE_W{1'b1}}};

  logic [mrms_pkg::ADDR_W-1:0] list_base [MAX_REGIONS];
  logic [mrms_pkg::SIZE_W-1:0] list_size [MAX_REGIONS];
  int                          list_len;
  logic [mrms_pkg::GAP_W-1:0]  gap_limit;
  logic [mrms_pkg::SIZE_W-1:0] min_limit;
  mrms_pkg::out_item_t         spans_due [$];
  int                          fails;

  initial begin
    fail_count = 0;
    pending    = 0;
    fails      = 0;
    list_len   = 0;
    gap_limit  = mrms_pkg::GAP_RESET;
    min_limit  = mrms_pkg::MIN_RESET;
  end

  function automatic bit keep_span(logic [63:0] lo, logic [63:0] hi);
    logic [63:0]         width;
    mrms_pkg::out_item_t span;
    width = hi - lo;
    if (width > SIZE_CAP) width = SIZE_CAP;
    if (width < {12'd0, min_limit}) return 1'b0;
    span.span_base = lo[mrms_pkg::ADDR_W-1:0];
    span.span_size = width[mrms_pkg::SIZE_W-1:0];
    span.span_last = 1'b0;
    span.none_left = 1'b0;
    spans_due.push_back(span);
    return 1'b1;
  endfunction

  function automatic void sanitize_list();
    logic [mrms_pkg::ADDR_W-1:0] sb [MAX_REGIONS];
    logic [mrms_pkg::SIZE_W-1:0] ss [MAX_REGIONS];
    logic [mrms_pkg::ADDR_W-1:0] kb;
    logic [mrms_pkg::SIZE_W-1:0] ks;
    logic [63:0]                 lo, hi, nb, ne;
    int                          j;
    int                          kept;
    mrms_pkg::out_item_t         span;
    for (int i = 0; i < list_len; i++) begin
      sb[i] = list_base[i];
      ss[i] = list_size[i];
    end
    for (int i = 1; i < list_len; i++) begin
      kb = sb[i];
      ks = ss[i];
      j = i;
      while (j > 0 && sb[j-1] > kb) begin
        sb[j] = sb[j-1];
        ss[j] = ss[j-1];
        j--;
      end
      sb[j] = kb;
      ss[j] = ks;
    end
    kept = 0;
    if (list_len > 0) begin
      lo = {12'd0, sb[0]};
      hi = lo + {12'd0, ss[0]};
      for (int i = 1; i < list_len; i++) begin
        nb = {12'd0, sb[i]};
        ne = nb + {12'd0, ss[i]};
        if (nb <= hi + {40'd0, gap_limit}) begin
          if (ne > hi) hi = ne;
        end else begin
          kept += keep_span(lo, hi);
          lo = nb;
          hi = ne;
        end
      end
      kept += keep_span(lo, hi);
    end
    if (kept == 0) begin
      span = '0;
      span.none_left = 1'b1;
      spans_due.push_back(span);
    end else begin
      span = spans_due.pop_back();
      span.span_last = 1'b1;
      spans_due.push_back(span);
    end
    list_len = 0;
  endfunction

  always @(posedge clk) begin
    mrms_pkg::out_item_t want;
    if (rst) begin
      list_len  = 0;
      gap_limit = mrms_pkg::GAP_RESET;
      min_limit = mrms_pkg::MIN_RESET;
      spans_due.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == mrms_pkg::REG_MERGE_GAP)
          gap_limit = cfg_data[mrms_pkg::GAP_W-1:0];
        else if (cfg_index == mrms_pkg::REG_MIN_SIZE)
          min_limit = cfg_data[mrms_pkg::SIZE_W-1:0];
      end
      if (start && !busy) begin
        if (list_len < MAX_REGIONS) begin
          list_base[list_len] = region.region_base;
          list_size[list_len] = region.region_size;
          list_len++;
        end
        if (region.last_region) sanitize_list();
      end
      if (result_valid) begin
        if (spans_due.size() == 0) begin
          $error("result transfer with no span due: span_base %h, span_size %h",
                 result.span_base, result.span_size);
          fails++;
        end else begin
          want = spans_due.pop_front();
          if (result.span_base !== want.span_base) begin
            $error("span_base: expected %h, actual %h", want.span_base, result.span_base);
            fails++;
          end
          if (result.span_size !== want.span_size) begin
            $error("span_size: expected %h, actual %h", want.span_size, result.span_size);
            fails++;
          end
          if (result.span_last !== want.span_last) begin
            $error("span_last: expected %b, actual %b", want.span_last, result.span_last);
            fails++;
          end
          if (result.none_left !== want.none_left) begin
            $error("none_left: expected %b, actual %b", want.none_left, result.none_left);
            fails++;
          end
        end
      end
    end
    fail_count <= fails;
    pending    <= spans_due.size();
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Memory region map sanitizer testbench
// Feeds region lists to the sanitizer in random bursts: a few directed lists
// at the extremes of base, size, gap and minimum size, then random clustered,
// wide and edge-valued lists, some long enough to overflow the store. The
// limits are rewritten between lists while the block is idle.
// ----------------------------------------------------------------------------

module tb;

  localparam int          MAX_REGIONS = 32;
  localparam int          SETTLE      = 3 * MAX_REGIONS + 16;
  localparam int          LIMIT       = 200000;
  localparam logic [51:0] ONES52      = {mrms_pkg::ADDR_W{1'b1}};

  typedef enum int {SHAPE_CLUSTER, SHAPE_WIDE, SHAPE_EDGE} list_shape_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             start = 1'b0;
  logic                             busy;
  mrms_pkg::in_item_t               region = '0;
  logic                             cfg_write = 1'b0;
  logic [mrms_pkg::CFG_INDEX_W-1:0] cfg_index = mrms_pkg::REG_MERGE_GAP;
  logic [mrms_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             result_valid;
  mrms_pkg::out_item_t              result;
  int                               fail_count;
  int                               pending;

  int                               cycle_count = 0;
  int                               burst_left = 0;
  int                               fed_items = 0;
  int                               lists_done = 0;
  logic [mrms_pkg::GAP_W-1:0]       cur_gap = mrms_pkg::GAP_RESET;
  logic [mrms_pkg::SIZE_W-1:0]      cur_min = mrms_pkg::MIN_RESET;

  always #5 clk = ~clk;

  memory_region_map_sanitizer #(.MAX_REGIONS(MAX_REGIONS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .region(region),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .result(result)
  );

  mrms_checker #(.MAX_REGIONS(MAX_REGIONS)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .region(region),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .result(result),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("memory_region_map_sanitizer regression: fail");
      $finish;
    end
  end

  function automatic logic [51:0] rand52();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[51:0];
  endfunction

  function automatic logic [51:0] edge52();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 52'd1;
      2: return ONES52;
      3: return ONES52 - 52'd1;
      default: return rand52();
    endcase
  endfunction

  function automatic mrms_pkg::in_item_t mk(logic [51:0] b, logic [51:0] s, logic l);
    mrms_pkg::in_item_t it;
    it.region_base = b;
    it.region_size = s;
    it.last_region = l;
    return it;
  endfunction

  task automatic wait_idle();
    do @(posedge clk); while (pending != 0 || busy);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limits(logic [mrms_pkg::GAP_W-1:0] gap,
                              logic [mrms_pkg::SIZE_W-1:0] min_size);
    logic [63:0] junk;
    wait_idle();
    junk = {$urandom(), $urandom()};
    cfg_write <= 1'b1;
    cfg_index <= mrms_pkg::REG_MERGE_GAP;
    cfg_data  <= {junk[27:0], gap};
    @(posedge clk);
    cfg_index <= mrms_pkg::REG_MIN_SIZE;
    cfg_data  <= min_size;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_gap = gap;
    cur_min = min_size;
  endtask

  task automatic random_limits();
    logic [mrms_pkg::GAP_W-1:0]  gap;
    logic [mrms_pkg::SIZE_W-1:0] min_size;
    case ($urandom_range(0, 4))
      0: gap = '0;
      1: gap = {mrms_pkg::GAP_W{1'b1}};
      2: gap = mrms_pkg::GAP_RESET;
      3: gap = mrms_pkg::GAP_W'($urandom_range(0, 'h4000));
      default: gap = mrms_pkg::GAP_W'($urandom());
    endcase
    case ($urandom_range(0, 4))
      0: min_size = '0;
      1: min_size = ONES52;
      2: min_size = mrms_pkg::MIN_RESET;
      3: min_size = mrms_pkg::SIZE_W'($urandom_range(0, 'h200000));
      default: min_size = mrms_pkg::SIZE_W'($urandom_range(0, 'h20000));
    endcase
    write_limits(gap, min_size);
  endtask

  // Holds start until the transfer, then either keeps start high for the
  // next item of the burst or drops it for a gap. Start always drops after
  // the last region so an idle block never picks up a stale item.
  task automatic feed_region(mrms_pkg::in_item_t it);
    int gap;
    region <= it;
    start  <= 1'b1;
    do @(posedge clk); while (busy);
    if (it.last_region || burst_left == 0) begin
      start <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
      if (burst_left == 0)
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  task automatic feed_list(int n, list_shape_t shape);
    mrms_pkg::in_item_t batch [$];
    mrms_pkg::in_item_t it;
    mrms_pkg::in_item_t tmp;
    logic [51:0]        cursor;
    logic [51:0]        sz;
    int                 k;
    cursor = ($urandom_range(0, 1) == 0) ? rand52() : 52'($urandom());
    for (int i = 0; i < n; i++) begin
      case (shape)
        SHAPE_CLUSTER: begin
          sz = 52'($urandom_range(0, 'h180000));
          it = mk(cursor, sz, 1'b0);
          case ($urandom_range(0, 4))
            0: cursor = cursor + sz + cur_gap;
            1: cursor = cursor + sz + cur_gap + 52'd1;
            2: cursor = cursor + (sz >> 1);
            3: cursor = cursor + sz + 52'($urandom_range(0, 2 * int'(cur_gap) + 64));
            default: cursor = cursor + sz + 52'($urandom_range(0, 'h100000)) * 16;
          endcase
        end
        SHAPE_WIDE: it = mk(rand52(), rand52(), 1'b0);
        default: it = mk(edge52(), edge52(), 1'b0);
      endcase
      batch.push_back(it);
    end
    if ($urandom_range(0, 1) == 0) begin
      for (int i = n - 1; i > 0; i--) begin
        k = $urandom_range(0, i);
        tmp = batch[i];
        batch[i] = batch[k];
        batch[k] = tmp;
      end
    end
    batch[n-1].last_region = 1'b1;
    foreach (batch[i]) feed_region(batch[i]);
    fed_items += (n < MAX_REGIONS) ? n : MAX_REGIONS;
    lists_done++;
  endtask

  initial begin
    int          n;
    list_shape_t shape;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    feed_region(mk('0, ONES52, 1'b1));
    feed_region(mk(ONES52, '0, 1'b1));
    // Two full-size regions that merge into a span wider than 52 bits.
    feed_region(mk(ONES52, ONES52, 1'b0));
    feed_region(mk('0, ONES52, 1'b1));
    // Gaps of exactly the merge distance and one byte more.
    feed_region(mk(52'h20_0000, 52'h10_0000, 1'b0));
    feed_region(mk(52'h0, 52'h10_0000, 1'b0));
    feed_region(mk(52'h30_1000, 52'h10_0000, 1'b0));
    feed_region(mk(52'h40_2001, 52'h10_0000, 1'b1));
    // Equal bases and a region inside another one.
    feed_region(mk(52'h100_0000, 52'h80_0000, 1'b0));
    feed_region(mk(52'h100_0000, 52'h10_0000, 1'b0));
    feed_region(mk(52'h110_0000, 52'h10, 1'b1));

    write_limits('0, '0);
    feed_region(mk(52'h10, 52'h10, 1'b0));
    feed_region(mk(52'h20, 52'h0, 1'b0));
    feed_region(mk(52'h20, 52'h5, 1'b0));
    feed_region(mk(52'h26, 52'h1, 1'b1));

    write_limits({mrms_pkg::GAP_W{1'b1}}, ONES52);
    feed_region(mk(52'h5, 52'h1, 1'b0));
    feed_region(mk(52'h100_0005, 52'h3, 1'b1));

    write_limits(mrms_pkg::GAP_RESET, mrms_pkg::MIN_RESET);
    fed_items = 0;
    while (fed_items < 120) begin
      if (lists_done % 6 == 0) random_limits();
      case ($urandom_range(0, 9))
        0: n = $urandom_range(MAX_REGIONS + 1, MAX_REGIONS + 8);
        1, 2: n = $urandom_range(7, MAX_REGIONS);
        default: n = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 5))
        0: shape = SHAPE_WIDE;
        1: shape = SHAPE_EDGE;
        default: shape = SHAPE_CLUSTER;
      endcase
      feed_list(n, shape);
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("memory_region_map_sanitizer regression: pass");
    end else begin
      $display("memory_region_map_sanitizer regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mrms_pkg.sv
rtl/mrms_cell.sv
rtl/mrms_merge.sv
rtl/memory_region_map_sanitizer.sv
verif/mrms_checker.sv
verif/tb.sv
